### hw/rtl/spfa_shortest_path_assert.svh
// Assertion macros for the SPFA shortest path block.
// Used by hw/rtl/spfa_shortest_path.sv; expects i_clk and i_rst_n in scope.
`ifndef SPFA_SHORTEST_PATH_ASSERT_SVH
`define SPFA_SHORTEST_PATH_ASSERT_SVH

// same-cycle implication, idle during reset
`define SPFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define SPFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/spfa_pkg.sv
// Shared types and constants of the SPFA shortest path block.
// No dependencies.
package spfa_pkg;

    localparam int NODES              = 256;
    localparam int NW                 = 8;
    localparam int EDGES_PER_NODE_DEF = 7;
    localparam int VISIT_W            = 9;
    localparam int DIST_W             = 48;
    localparam int WEIGHT_W           = 32;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NEGCYC = 2'd2;

    typedef struct packed {
        logic [DIST_W-1:0]  best_dist;
        logic               reached;
        logic               has_prev;
        logic [NW-1:0]      prev;
        logic               queued;
        logic [VISIT_W-1:0] visit;
    } t_node;

endpackage

### hw/rtl/spfa_shortest_path.sv
// SPFA shortest path: edge loads, runs from a start node, node queries.
// Most state sits in single-port read, registered memories (node, edge, ecnt, queue).
// Reset: synchronous active low; a clearing pass follows, input held off.
// Each run starts with a clearing pass over the node memory alone.
`include "spfa_shortest_path_assert.svh"
module spfa_shortest_path #(
    parameter int EDGES_PER_NODE = spfa_pkg::EDGES_PER_NODE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_req_type,
    input  logic [spfa_pkg::NW-1:0]              i_edge_from,
    input  logic [spfa_pkg::NW-1:0]              i_edge_to,
    input  logic signed [spfa_pkg::WEIGHT_W-1:0] i_edge_weight,
    input  logic [spfa_pkg::NW-1:0]              i_start_node,
    input  logic [spfa_pkg::NW-1:0]              i_query_node,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [1:0]                           o_status,
    output logic signed [spfa_pkg::DIST_W-1:0]   o_distance,
    output logic                                 o_reachable,
    output logic [spfa_pkg::NW-1:0]              o_predecessor,
    output logic                                 o_has_predecessor
);
    import spfa_pkg::*;

    localparam int SW = (EDGES_PER_NODE > 1) ? $clog2(EDGES_PER_NODE) : 1;
    localparam int CW = $clog2(EDGES_PER_NODE + 1);
    localparam int EA = NW + SW;
    localparam int EW = WEIGHT_W + NW;
    localparam logic [CW-1:0] EPN = CW'(EDGES_PER_NODE);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_LD   = 4'd2;
    localparam logic [3:0] S_LDW  = 4'd3;
    localparam logic [3:0] S_QRY  = 4'd4;
    localparam logic [3:0] S_QRYW = 4'd5;
    localparam logic [3:0] S_START= 4'd6;
    localparam logic [3:0] S_POP  = 4'd7;
    localparam logic [3:0] S_POPW = 4'd8;
    localparam logic [3:0] S_URD  = 4'd9;
    localparam logic [3:0] S_ERD  = 4'd10;
    localparam logic [3:0] S_EV   = 4'd11;
    localparam logic [3:0] S_EUP  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    // memories
    t_node          node_mem [NODES];
    logic [EW-1:0]  edge_mem [NODES << SW];
    logic [CW-1:0]  ecnt_mem [NODES];
    logic [NW-1:0]  queue_mem[NODES];

    t_node          node_rd;
    logic [EW-1:0]  edge_rd;
    logic [CW-1:0]  ecnt_rd;
    logic [NW-1:0]  queue_rd;

    logic           node_we, edge_we, ecnt_we, queue_we;
    logic [NW-1:0]  node_wa, node_ra, ecnt_wa, ecnt_ra, queue_wa, queue_ra;
    logic [EA-1:0]  edge_wa, edge_ra;
    t_node          node_wd;
    logic [EW-1:0]  edge_wd;
    logic [CW-1:0]  ecnt_wd;
    logic [NW-1:0]  queue_wd;

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_wa] <= node_wd;
        end
        node_rd <= node_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[edge_wa] <= edge_wd;
        end
        edge_rd <= edge_mem[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ecnt_we) begin
            ecnt_mem[ecnt_wa] <= ecnt_wd;
        end
        ecnt_rd <= ecnt_mem[ecnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (queue_we) begin
            queue_mem[queue_wa] <= queue_wd;
        end
        queue_rd <= queue_mem[queue_ra];
    end

    // registers
    logic [3:0]           r_state, n_state;
    logic [NW:0]          r_addr, n_addr;
    logic                 r_clr_all, n_clr_all;
    logic [NW-1:0]        r_head, n_head, r_tail, n_tail;
    logic [NW:0]          r_fill, n_fill;
    logic [NW:0]          r_ncount, n_ncount;
    logic [NW-1:0]        r_u, n_u;
    logic signed [DIST_W-1:0] r_du, n_du;
    logic [CW-1:0]        r_cnt, n_cnt, r_slot, n_slot;
    logic [1:0]           r_type;
    logic [NW-1:0]        r_from, r_to, r_s, r_q;
    logic signed [WEIGHT_W-1:0] r_w;
    logic [1:0]           r_status, n_status;
    logic signed [DIST_W-1:0] r_dist, n_dist;
    logic                 r_reach, n_reach, r_hasp, n_hasp;
    logic [NW-1:0]        r_pred, n_pred;
    logic                 r_ovalid, n_ovalid;
    logic [1:0]           r_o_status;
    logic signed [DIST_W-1:0] r_o_dist;
    logic                 r_o_reach, r_o_hasp;
    logic [NW-1:0]        r_o_pred;

    logic                 in_xfer, out_load;
    logic signed [DIST_W-1:0] cand;
    logic [NW-1:0]        top_node;

    spfa_relax u_relax (
        .i_clk   (i_clk),
        .i_base  (r_du),
        .i_weight(edge_rd[EW-1:NW]),
        .o_cand  (cand)
    );

    assign in_xfer  = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_ready);
    assign top_node = (r_from > r_to) ? r_from : r_to;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_clr_all = r_clr_all;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_ncount  = r_ncount;
        n_u       = r_u;
        n_du      = r_du;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        n_status  = r_status;
        n_dist    = r_dist;
        n_reach   = r_reach;
        n_hasp    = r_hasp;
        n_pred    = r_pred;
        node_we   = 1'b0;
        node_wa   = r_addr[NW-1:0];
        node_wd   = '0;
        node_ra   = r_q;
        edge_we   = 1'b0;
        edge_wa   = {r_from, ecnt_rd[SW-1:0]};
        edge_wd   = {r_w, r_to};
        edge_ra   = {r_u, r_slot[SW-1:0]};
        ecnt_we   = 1'b0;
        ecnt_wa   = r_addr[NW-1:0];
        ecnt_wd   = '0;
        ecnt_ra   = r_from;
        queue_we  = 1'b0;
        queue_wa  = r_tail;
        queue_wd  = r_s;
        queue_ra  = r_head;

        case (r_state)
            S_CLR: begin
                node_we = 1'b1;
                ecnt_we = r_clr_all;
                n_addr  = r_addr + 1'b1;
                if (r_addr[NW-1:0] == NW'(NODES - 1)) begin
                    n_state = r_clr_all ? S_IDLE : S_START;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_status = ST_OK;
                    n_dist   = '0;
                    n_reach  = 1'b0;
                    n_hasp   = 1'b0;
                    n_pred   = '0;
                    case (i_req_type)
                        REQ_LOAD:  n_state = S_LD;
                        REQ_RUN: begin
                            n_state   = S_CLR;
                            n_clr_all = 1'b0;
                            n_addr    = '0;
                            n_head    = '0;
                            n_tail    = '0;
                            n_fill    = '0;
                        end
                        REQ_QUERY: n_state = S_QRY;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_LD: begin
                n_state = S_LDW;
            end
            S_LDW: begin
                if (ecnt_rd >= EPN) begin
                    n_status = ST_FULL;
                end else begin
                    edge_we = 1'b1;
                    ecnt_we = 1'b1;
                    ecnt_wa = r_from;
                    ecnt_wd = ecnt_rd + 1'b1;
                    if ({1'b0, top_node} + 1'b1 > r_ncount) begin
                        n_ncount = {1'b0, top_node} + 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_QRY: begin
                n_state = S_QRYW;
            end
            S_QRYW: begin
                n_reach = node_rd.reached;
                n_dist  = node_rd.reached ? node_rd.best_dist : '0;
                n_hasp  = node_rd.has_prev;
                n_pred  = node_rd.has_prev ? node_rd.prev : '0;
                n_state = S_DONE;
            end
            S_START: begin
                node_we          = 1'b1;
                node_wa          = r_s;
                node_wd.reached  = 1'b1;
                node_wd.queued   = 1'b1;
                queue_we         = 1'b1;
                n_tail           = r_tail + 1'b1;
                n_fill           = r_fill + 1'b1;
                n_state          = S_POP;
            end
            S_POP: begin
                if (r_fill == '0) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_head  = r_head + 1'b1;
                    n_fill  = r_fill - 1'b1;
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                node_ra = queue_rd;
                ecnt_ra = queue_rd;
                n_u     = queue_rd;
                n_state = S_URD;
            end
            S_URD: begin
                if (node_rd.visit > r_ncount) begin
                    n_status = ST_NEGCYC;
                    n_state  = S_DONE;
                end else begin
                    node_we        = 1'b1;
                    node_wa        = r_u;
                    node_wd        = node_rd;
                    node_wd.visit  = node_rd.visit + 1'b1;
                    node_wd.queued = 1'b0;
                    n_du           = node_rd.best_dist;
                    n_cnt          = ecnt_rd;
                    n_slot         = '0;
                    n_state        = (ecnt_rd == '0) ? S_POP : S_ERD;
                end
            end
            S_ERD: begin
                n_state = S_EV;
            end
            S_EV: begin
                node_ra = edge_rd[NW-1:0];
                n_state = S_EUP;
            end
            S_EUP: begin
                if (!node_rd.reached || cand < $signed(node_rd.best_dist)) begin
                    node_we           = 1'b1;
                    node_wa           = edge_rd[NW-1:0];
                    node_wd.best_dist = cand;
                    node_wd.reached   = 1'b1;
                    node_wd.has_prev  = 1'b1;
                    node_wd.prev      = r_u;
                    node_wd.queued    = 1'b1;
                    node_wd.visit     = node_rd.visit;
                    if (edge_rd[NW-1:0] == r_u) begin
                        n_du = cand;
                    end
                    if (!node_rd.queued) begin
                        queue_we = 1'b1;
                        queue_wd = edge_rd[NW-1:0];
                        n_tail   = r_tail + 1'b1;
                        n_fill   = r_fill + 1'b1;
                    end
                end
                n_slot  = r_slot + 1'b1;
                n_state = (r_slot + 1'b1 < r_cnt) ? S_ERD : S_POP;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovalid = r_ovalid;
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_addr    <= '0;
            r_clr_all <= 1'b1;
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_ncount  <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_clr_all <= n_clr_all;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fill    <= n_fill;
            r_ncount  <= n_ncount;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u      <= n_u;
        r_du     <= n_du;
        r_cnt    <= n_cnt;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_dist   <= n_dist;
        r_reach  <= n_reach;
        r_hasp   <= n_hasp;
        r_pred   <= n_pred;
        if (in_xfer) begin
            r_type <= i_req_type;
            r_from <= i_edge_from;
            r_to   <= i_edge_to;
            r_w    <= i_edge_weight;
            r_s    <= i_start_node;
            r_q    <= i_query_node;
        end
        if (out_load) begin
            r_o_status <= r_status;
            r_o_dist   <= r_dist;
            r_o_reach  <= r_reach;
            r_o_hasp   <= r_hasp;
            r_o_pred   <= r_pred;
        end
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_status          = r_o_status;
    assign o_distance        = r_o_dist;
    assign o_reachable       = r_o_reach;
    assign o_predecessor     = r_o_pred;
    assign o_has_predecessor = r_o_hasp;

    `SPFA_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= (NW+1)'(NODES), "queue fill beyond depth")
    `SPFA_ASSERT_IMP(a_empty_ptrs, r_fill == '0, r_head == r_tail, "empty queue with split pointers")
    `SPFA_ASSERT_NXT(a_accept_busy, in_xfer, r_state != S_IDLE, "idle after accepting a request")
    `SPFA_ASSERT_NXT(a_load_done, r_state == S_LDW, r_state == S_DONE && r_type == REQ_LOAD,
        "load did not finish in one step")

endmodule

### hw/rtl/spfa_relax.sv
// Registered saturating candidate distance: base plus sign-extended weight.
// Depends on spfa_pkg.
module spfa_relax (
    input  logic                                 i_clk,
    input  logic signed [spfa_pkg::DIST_W-1:0]   i_base,
    input  logic signed [spfa_pkg::WEIGHT_W-1:0] i_weight,
    output logic signed [spfa_pkg::DIST_W-1:0]   o_cand
);
    import spfa_pkg::*;

    logic signed [DIST_W:0]   sum;
    logic signed [DIST_W-1:0] r_cand;

    assign sum = {i_base[DIST_W-1], i_base}
               + {{(DIST_W + 1 - WEIGHT_W){i_weight[WEIGHT_W-1]}}, i_weight};

    always_ff @(posedge i_clk) begin
        if (sum[DIST_W] != sum[DIST_W-1]) begin
            r_cand <= sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
        end else begin
            r_cand <= sum[DIST_W-1:0];
        end
    end

    assign o_cand = r_cand;

endmodule

### test/spfa_shortest_path_test.sv
// Self-checking testbench of spfa_shortest_path: directed table, then random traffic.
// Depends on spfa_pkg and the block; its own SPFA model predicts non-fixed rows.
`timescale 1ns / 100ps
module spfa_shortest_path_test;
    import spfa_pkg::*;

    localparam logic [1:0] REQ_IDLE = 2'd3;
    localparam int EPN = EDGES_PER_NODE_DEF;
    localparam int NONE_NODE = NODES;
    localparam int IDLE_LIMIT = 8000000;
    localparam int RANDOM_ITEMS = 1700;
    localparam longint D48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint D48_MIN = -D48_MAX - 1;

    typedef struct packed {
        logic [1:0]        status;
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic [NW-1:0]     predecessor;
        logic              has_pred;
    } t_path_result;

    typedef struct {
        logic [1:0]    kind;
        logic [NW-1:0] from;
        logic [NW-1:0] to;
        logic [31:0]   weight;
        logic [NW-1:0] start;
        logic [NW-1:0] query;
        bit            fixed;
        t_path_result  typed;
    } t_req_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [1:0]                 i_req_type;
    logic [NW-1:0]              i_edge_from;
    logic [NW-1:0]              i_edge_to;
    logic signed [WEIGHT_W-1:0] i_edge_weight;
    logic [NW-1:0]              i_start_node;
    logic [NW-1:0]              i_query_node;
    logic                       o_valid;
    logic                       i_ready;
    logic [1:0]                 o_status;
    logic signed [DIST_W-1:0]   o_distance;
    logic                       o_reachable;
    logic [NW-1:0]              o_predecessor;
    logic                       o_has_predecessor;

    spfa_shortest_path DUT (.*);

    // graph and path state of the predictor
    int     edge_dst [NODES][EPN];
    longint edge_wt  [NODES][EPN];
    int     edge_cnt [NODES];
    int     node_total;
    longint dist_tab [NODES];
    bit     reach_tab[NODES];
    int     pred_tab [NODES];

    t_path_result pending_results[$];
    t_req_row     dir_rows[$];
    int           error_count;
    int           idle_cycles;

    function automatic logic [1:0] relax_paths(int s);
        bit on_queue[NODES];
        int visits[NODES];
        int work[$];
        int u, v;
        longint cand;
        for (int i = 0; i < NODES; i++) begin
            reach_tab[i] = 0;
            pred_tab[i] = NONE_NODE;
            on_queue[i] = 0;
            visits[i] = 0;
        end
        dist_tab[s] = 0;
        reach_tab[s] = 1;
        work.push_back(s);
        on_queue[s] = 1;
        while (work.size() != 0) begin
            u = work.pop_front();
            on_queue[u] = 0;
            if (visits[u] > node_total) return ST_NEGCYC;
            visits[u]++;
            for (int i = 0; i < edge_cnt[u]; i++) begin
                v = edge_dst[u][i];
                cand = dist_tab[u] + edge_wt[u][i];
                if (cand > D48_MAX) cand = D48_MAX;
                if (cand < D48_MIN) cand = D48_MIN;
                if (!reach_tab[v] || cand < dist_tab[v]) begin
                    dist_tab[v] = cand;
                    reach_tab[v] = 1;
                    pred_tab[v] = u;
                    if (!on_queue[v]) begin
                        work.push_back(v);
                        on_queue[v] = 1;
                    end
                end
            end
        end
        return ST_OK;
    endfunction

    function automatic t_path_result path_step(t_req_row r);
        t_path_result res;
        int k, f, t;
        res = '0;
        f = int'(r.from);
        t = int'(r.to);
        case (r.kind)
            REQ_LOAD: begin
                k = edge_cnt[f];
                if (k >= EPN) begin
                    res.status = ST_FULL;
                end else begin
                    edge_dst[f][k] = t;
                    edge_wt[f][k] = longint'($signed(r.weight));
                    edge_cnt[f] = k + 1;
                    if ((f > t ? f : t) + 1 > node_total) node_total = (f > t ? f : t) + 1;
                end
            end
            REQ_RUN: res.status = relax_paths(int'(r.start));
            REQ_QUERY: begin
                if (reach_tab[r.query]) begin
                    res.distance = dist_tab[r.query][DIST_W-1:0];
                    res.reachable = 1;
                end
                if (pred_tab[r.query] < NODES) begin
                    res.predecessor = pred_tab[r.query][NW-1:0];
                    res.has_pred = 1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic add_row(logic [1:0] kind, int from, int to, logic [31:0] w, int start,
                           int query, bit fixed, t_path_result typed);
        t_req_row r;
        r.kind = kind;
        r.from = NW'(from);
        r.to = NW'(to);
        r.weight = w;
        r.start = NW'(start);
        r.query = NW'(query);
        r.fixed = fixed;
        r.typed = typed;
        dir_rows.push_back(r);
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_transfer(t_req_row r, int gap);
        t_path_result res;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= r.kind;
        i_edge_from <= r.from;
        i_edge_to <= r.to;
        i_edge_weight <= r.weight;
        i_start_node <= r.start;
        i_query_node <= r.query;
        do @(posedge i_clk); while (!o_ready);
        res = path_step(r);
        if (r.fixed) res = r.typed;
        pending_results.push_back(res);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        t_path_result zero_res, ok_res, full_res, neg_res, start_res;
        t_req_row r;
        bit calm;
        int sel, f;
        zero_res = '0;
        ok_res = '0;
        full_res = '0;
        full_res.status = ST_FULL;
        neg_res = '0;
        neg_res.status = ST_NEGCYC;
        start_res = '0;
        start_res.reachable = 1;
        for (int i = 0; i < NODES; i++) begin
            edge_cnt[i] = 0;
            reach_tab[i] = 0;
            pred_tab[i] = NONE_NODE;
            dist_tab[i] = 0;
        end
        node_total = 0;
        error_count = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req_type <= REQ_LOAD;
        i_edge_from <= '0;
        i_edge_to <= '0;
        i_edge_weight <= '0;
        i_start_node <= '0;
        i_query_node <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(REQ_QUERY, 0, 0, 0, 0, 0, 1, zero_res);
        add_row(REQ_IDLE, 255, 255, 32'hFFFF_FFFF, 255, 255, 1, zero_res);
        add_row(REQ_LOAD, 0, 1, 32'h0001_0000, 0, 0, 1, ok_res);
        add_row(REQ_LOAD, 1, 2, 32'h7FFF_FFFF, 0, 0, 1, ok_res);
        add_row(REQ_LOAD, 0, 2, 32'h8000_0000, 0, 0, 1, ok_res);
        add_row(REQ_RUN, 0, 0, 0, 100, 0, 1, ok_res);
        add_row(REQ_QUERY, 0, 0, 0, 0, 100, 1, start_res);
        add_row(REQ_QUERY, 0, 0, 0, 0, 0, 1, zero_res);
        add_row(REQ_LOAD, 200, 201, 32'hFFFF_0000, 0, 0, 1, ok_res);
        add_row(REQ_LOAD, 201, 200, 32'h0000_0000, 0, 0, 1, ok_res);
        for (int i = 0; i < EPN; i++)
            add_row(REQ_LOAD, 5, 6 + i, 32'h0000_1000 * i, 0, 0, 1, ok_res);
        add_row(REQ_LOAD, 5, 6, 32'h1234_5678, 0, 0, 1, full_res);
        add_row(REQ_LOAD, 255, 254, 32'h0000_0001, 0, 0, 1, ok_res);
        add_row(REQ_RUN, 0, 0, 0, 0, 0, 1, ok_res);
        add_row(REQ_QUERY, 0, 0, 0, 0, 2, 0, zero_res);
        add_row(REQ_QUERY, 0, 0, 0, 0, 1, 0, zero_res);
        add_row(REQ_QUERY, 0, 0, 0, 0, 255, 1, zero_res);
        add_row(REQ_RUN, 0, 0, 0, 200, 0, 1, neg_res);
        add_row(REQ_QUERY, 0, 0, 0, 0, 201, 0, zero_res);

        foreach (dir_rows[i]) send_transfer(dir_rows[i], $urandom_range(0, 15));

        calm = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 31) == 0) calm = ~calm;
            sel = $urandom_range(0, 99);
            r.fixed = 0;
            r.typed = zero_res;
            r.from = NW'($urandom);
            r.to = NW'($urandom);
            r.weight = $urandom;
            r.start = NW'($urandom);
            r.query = NW'($urandom);
            if (sel < 45) begin
                r.kind = REQ_LOAD;
                r.from = NW'($urandom_range(0, 15));
                r.to = NW'($urandom_range(0, 15));
                r.weight = $urandom_range(0, 32'h0003_FFFF);
            end else if (sel < 52) begin
                // forward-only edges: any weight
                r.kind = REQ_LOAD;
                f = $urandom_range(0, 254);
                r.from = NW'(f);
                r.to = NW'($urandom_range(f + 1, 255));
            end else if (sel < 57) begin
                r.kind = REQ_RUN;
                if ($urandom_range(0, 9) < 7) r.start = NW'($urandom_range(0, 15));
            end else if (sel < 96) begin
                r.kind = REQ_QUERY;
                if ($urandom_range(0, 1)) r.query = NW'($urandom_range(0, 15));
            end else begin
                r.kind = REQ_IDLE;
            end
            send_transfer(r, calm ? 0 : $urandom_range(0, 15));
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (error_count == 0)
            $display("spfa_shortest_path_test: done, clean");
        else
            $display("spfa_shortest_path_test: done, errors");
        $finish;
    end

    initial begin
        t_path_result want;
        bit calm;
        int stall;
        calm = 0;
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) calm = ~calm;
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(o_status), 64'(0));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_distance !== want.distance)
                    report_mismatch("distance", 64'(unsigned'(o_distance)),
                                    64'(want.distance));
                if (o_reachable !== want.reachable)
                    report_mismatch("reachable", 64'(o_reachable), 64'(want.reachable));
                if (o_predecessor !== want.predecessor)
                    report_mismatch("predecessor", 64'(o_predecessor), 64'(want.predecessor));
                if (o_has_predecessor !== want.has_pred)
                    report_mismatch("has_predecessor", 64'(o_has_predecessor),
                                    64'(want.has_pred));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("spfa_shortest_path_test: done, errors");
                $finish;
            end
        end
    end

endmodule
